// ===== hdl/rgbc_pkg.sv =====
// Package for the RGB 2-D convolution block: sizes, item codes, shared types
// and the output rounding and clamping function.
// No dependencies; every other file of the block but rgbc_ram imports it.
package rgbc_pkg;

    localparam int MAX_KERNEL = 5;
    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 1024;

    localparam int NTAP     = MAX_KERNEL * MAX_KERNEL;
    localparam int NCHAN    = 3;
    localparam int NROWBUF  = MAX_KERNEL - 1;

    localparam int CFG_W    = 11;
    localparam int KSZ_W    = 3;
    localparam int KIND_W   = 2;
    localparam int CIDX_W   = 5;
    localparam int COEF_W   = 16;
    localparam int PIX_W    = 8;
    localparam int POS_W    = 10;
    localparam int CFGA_W   = 2;

    localparam int WIDTH_RESET  = 1024;
    localparam int HEIGHT_RESET = 1024;
    localparam int KSIZE_RESET  = 3;

    localparam int DIM_MAX  = (MAX_HEIGHT > MAX_WIDTH) ? MAX_HEIGHT : MAX_WIDTH;
    localparam int CNT_W    = $clog2(DIM_MAX + MAX_KERNEL);
    localparam int ADDR_W   = $clog2(MAX_WIDTH);
    localparam int SAMPLE_W = NCHAN * PIX_W;
    localparam int LINE_W   = NROWBUF * SAMPLE_W;

    localparam int FRAC_BITS = 10;
    localparam int PIX_MAX   = 255;
    localparam int PROD_W    = PIX_W + 1 + COEF_W;
    localparam int ROW_W     = PROD_W + $clog2(MAX_KERNEL + 1);
    localparam int ACC_W     = PROD_W + $clog2(NTAP + 1);

    typedef enum logic [KIND_W-1:0] {
        KIND_LOAD  = 2'd0,
        KIND_PIXEL = 2'd1,
        KIND_DRAIN = 2'd2
    } kind_t;

    typedef enum logic [CFGA_W-1:0] {
        CFG_IMAGE_WIDTH  = 2'd0,
        CFG_IMAGE_HEIGHT = 2'd1,
        CFG_KERNEL_SIZE  = 2'd2
    } cfg_reg_t;

    typedef logic [SAMPLE_W-1:0] sample_t;
    typedef logic signed [COEF_W-1:0] coef_t;
    typedef logic [MAX_KERNEL-1:0][MAX_KERNEL-1:0][SAMPLE_W-1:0] window_t;
    typedef logic [NTAP-1:0][PIX_W-1:0] tap_pix_t;
    typedef logic [NTAP-1:0][COEF_W-1:0] tap_coef_t;

    // control from the sequencer to the line buffer
    typedef struct packed {
        logic              en;
        logic              push;
        logic [ADDR_W-1:0] raddr;
        logic [ADDR_W-1:0] waddr;
    } win_ctrl_t;

    // what travels alongside an item down the pipe
    typedef struct packed {
        logic             emit;
        logic             last;
        logic [CNT_W-1:0] row;
        logic [CNT_W-1:0] col;
    } res_tag_t;

    // drop the fraction toward zero, clamp to the pixel range
    function automatic logic [PIX_W-1:0] finish_pix(input logic signed [ACC_W-1:0] acc);
        logic signed [ACC_W-1:0] sh;
        sh = acc >>> FRAC_BITS;
        if (acc <= 0)
            return '0;
        if (sh > $signed(ACC_W'(PIX_MAX)))
            return PIX_W'(PIX_MAX);
        return sh[PIX_W-1:0];
    endfunction

endpackage

// ===== hdl/rgbc_if.sv =====
// Channel interfaces of the RGB 2-D convolution block: input requests,
// results and configuration writes. Depends on rgbc_pkg.
interface rgbc_pix_if;
    import rgbc_pkg::*;
    logic                     valid;
    logic                     ready;
    logic [KIND_W-1:0]        kind;
    logic [CIDX_W-1:0]        coef_index;
    logic signed [COEF_W-1:0] coef_value;
    logic [PIX_W-1:0]         red_in;
    logic [PIX_W-1:0]         green_in;
    logic [PIX_W-1:0]         blue_in;

    modport source (output valid, kind, coef_index, coef_value, red_in, green_in, blue_in,
                    input ready);
    modport sink   (input valid, kind, coef_index, coef_value, red_in, green_in, blue_in,
                    output ready);
endinterface

interface rgbc_res_if;
    import rgbc_pkg::*;
    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] red_out;
    logic [PIX_W-1:0] green_out;
    logic [PIX_W-1:0] blue_out;
    logic [POS_W-1:0] out_row;
    logic [POS_W-1:0] out_col;
    logic             frame_last;

    modport source (output valid, red_out, green_out, blue_out, out_row, out_col, frame_last,
                    input ready);
    modport sink   (input valid, red_out, green_out, blue_out, out_row, out_col, frame_last,
                    output ready);
endinterface

interface rgbc_cfg_if;
    import rgbc_pkg::*;
    logic              valid;
    logic              ready;
    logic [CFGA_W-1:0] index;
    logic [CFG_W-1:0]  data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== hdl/rgbc_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module rgbc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                     clk,
    input  logic                                     we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                         wdata,
    input  logic                                     re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== hdl/rgbc_window.sv =====
// Line buffer and sliding window: row delay lines in one RAM plus the
// square window of sample registers. Depends on rgbc_pkg and rgbc_ram.
module rgbc_window (
    input  logic                 clk,
    input  logic                 rst_n,
    input  rgbc_pkg::win_ctrl_t  ctrl,
    input  rgbc_pkg::sample_t    sample,
    output rgbc_pkg::window_t    win
);
    import rgbc_pkg::*;

    logic [LINE_W-1:0]                      ram_rdata;
    logic [LINE_W-1:0]                      rd_data;
    logic [LINE_W-1:0]                      wr_data;
    logic [LINE_W-1:0]                      byp_data_reg;
    logic                                   byp_hit_reg;
    logic                                   we;
    logic [MAX_KERNEL-1:0][SAMPLE_W-1:0]    column;
    window_t                                win_reg;

    assign we = ctrl.en & ctrl.push;

    rgbc_ram #(
        .WIDTH (LINE_W),
        .DEPTH (MAX_WIDTH)
    ) u_line_ram (
        .clk   (clk),
        .we    (we),
        .waddr (ctrl.waddr),
        .wdata (wr_data),
        .re    (ctrl.en),
        .raddr (ctrl.raddr),
        .rdata (ram_rdata)
    );

    // a one-pixel-wide image reads the entry written in the same cycle
    assign rd_data = byp_hit_reg ? byp_data_reg : ram_rdata;

    always_comb
    begin
        column[0] = sample;
        for (int i = 1; i < MAX_KERNEL; i++)
        begin
            column[i] = rd_data[(i-1)*SAMPLE_W +: SAMPLE_W];
        end
        for (int i = 0; i < NROWBUF; i++)
        begin
            wr_data[i*SAMPLE_W +: SAMPLE_W] = column[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byp_hit_reg <= 1'b0;
        end
        else if (ctrl.en)
        begin
            byp_hit_reg <= we && (ctrl.waddr == ctrl.raddr);
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.en)
        begin
            byp_data_reg <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_reg <= '0;
        end
        else if (we)
        begin
            for (int j = 0; j < MAX_KERNEL; j++)
            begin
                win_reg[j][0] <= column[j];
                for (int x = 1; x < MAX_KERNEL; x++)
                begin
                    win_reg[j][x] <= win_reg[j][x-1];
                end
            end
        end
    end

    assign win = win_reg;

endmodule

// ===== hdl/rgbc_lane.sv =====
// One color lane: multiplies every window tap by its coefficient and sums
// the products through a registered two-level tree. Depends on rgbc_pkg.
module rgbc_lane (
    input  logic                              clk,
    input  logic                              en,
    input  rgbc_pkg::tap_pix_t                pix,
    input  rgbc_pkg::tap_coef_t               coef,
    output logic signed [rgbc_pkg::ACC_W-1:0] acc
);
    import rgbc_pkg::*;

    logic signed [PROD_W-1:0] pe      [NTAP];
    logic signed [PROD_W-1:0] ce      [NTAP];
    logic signed [PROD_W-1:0] prod_reg [NTAP];
    logic signed [ROW_W-1:0]  row_next [MAX_KERNEL];
    logic signed [ROW_W-1:0]  row_reg  [MAX_KERNEL];
    logic signed [ACC_W-1:0]  acc_next;
    logic signed [ACC_W-1:0]  acc_reg;

    always_comb
    begin
        for (int t = 0; t < NTAP; t++)
        begin
            pe[t] = PROD_W'($signed({1'b0, pix[t]}));
            ce[t] = PROD_W'($signed(coef[t]));
        end
    end

    always_comb
    begin
        for (int r = 0; r < MAX_KERNEL; r++)
        begin
            row_next[r] = '0;
            for (int x = 0; x < MAX_KERNEL; x++)
            begin
                row_next[r] = row_next[r] + ROW_W'(prod_reg[r*MAX_KERNEL + x]);
            end
        end
        acc_next = '0;
        for (int r = 0; r < MAX_KERNEL; r++)
        begin
            acc_next = acc_next + ACC_W'(row_reg[r]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int t = 0; t < NTAP; t++)
            begin
                prod_reg[t] <= pe[t] * ce[t];
            end
            for (int r = 0; r < MAX_KERNEL; r++)
            begin
                row_reg[r] <= row_next[r];
            end
            acc_reg <= acc_next;
        end
    end

    assign acc = acc_reg;

endmodule

// ===== hdl/rgb_2d_convolution_clamped.sv =====
// Top level of the RGB 2-D convolution block with zero padding and clamping.
// Depends on rgbc_pkg, rgbc_if, rgbc_window, rgbc_lane (and rgbc_ram below it).
//
//   channel  | dir | handshake      | carries
//   ---------+-----+----------------+---------------------------------------------
//   pixel    | in  | valid / ready  | kind, coef_index, coef_value, red/green/blue_in
//   result   | out | valid / ready  | red/green/blue_out, out_row, out_col, frame_last
//   cfg      | in  | valid / ready  | index, data (width, height, kernel size)
//
// One request is taken per clock while the pipe is not stalled. A result
// passes these registers after the request that completes its window:
// sequencer register, line RAM read and window shift, tap multipliers, row
// sums, total, output register. Each enabled cycle reads the line RAM; stream requests write it.
// Reset clears counters, window, coefficients and the pipe; the line RAM is not
// cleared, since every unwritten entry it could return lies outside the image.
// The pipe stalls only when a result waits at the output and the next result
// is about to reach it; other requests keep flowing.
module rgb_2d_convolution_clamped (
    input  logic       clk,
    input  logic       rst_n,
    rgbc_pix_if.sink   pixel,
    rgbc_res_if.source result,
    rgbc_cfg_if.sink   cfg
);
    import rgbc_pkg::*;

    // configuration
    logic [CFG_W-1:0] width_cfg_reg;
    logic [CFG_W-1:0] height_cfg_reg;
    logic [KSZ_W-1:0] ksize_cfg_reg;
    logic [CNT_W-1:0] w_eff;
    logic [CNT_W-1:0] h_eff;
    logic [KSZ_W-1:0] k_eff;
    logic [KSZ_W-1:0] half;

    // raster counters
    logic [CNT_W-1:0] in_row_reg,  in_row_next;
    logic [CNT_W-1:0] in_col_reg,  in_col_next;
    logic [CNT_W-1:0] out_row_reg, out_row_next;
    logic [CNT_W-1:0] out_col_reg, out_col_next;
    logic [CNT_W-1:0] in_col_inc;
    logic [CNT_W-1:0] out_col_inc;

    // request decode
    logic en;
    logic take;
    logic is_stream;
    logic is_load;
    logic emit_a;
    logic last_a;
    logic [2*CNT_W-1:0] pos_a;
    logic [2*CNT_W-1:0] delay_a;
    logic [MAX_KERNEL-1:0] rowok_a;
    logic [MAX_KERNEL-1:0] colok_a;
    sample_t sample_a;

    // sequencer stage
    logic                  a_valid_reg;
    logic                  a_stream_reg;
    logic                  a_load_reg;
    res_tag_t              a_tag_reg;
    logic [MAX_KERNEL-1:0] a_rowok_reg;
    logic [MAX_KERNEL-1:0] a_colok_reg;
    sample_t               a_sample_reg;
    logic [ADDR_W-1:0]     a_addr_reg;
    logic [CIDX_W-1:0]     a_cidx_reg;
    coef_t                 a_cval_reg;

    // window stage
    logic                  b_load_reg;
    res_tag_t              b_tag_reg;
    logic [MAX_KERNEL-1:0] b_rowok_reg;
    logic [MAX_KERNEL-1:0] b_colok_reg;
    logic [CIDX_W-1:0]     b_cidx_reg;
    coef_t                 b_cval_reg;

    win_ctrl_t win_ctrl;
    window_t   win;

    coef_t     coef_reg [NTAP];
    tap_pix_t  lane_pix [NCHAN];
    tap_coef_t lane_coef;
    logic signed [ACC_W-1:0] lane_acc [NCHAN];

    // tags riding with the lane stages
    res_tag_t p_tag_reg;
    res_tag_t s1_tag_reg;
    res_tag_t s2_tag_reg;

    // output register
    logic             out_valid_reg;
    logic [PIX_W-1:0] red_reg;
    logic [PIX_W-1:0] green_reg;
    logic [PIX_W-1:0] blue_reg;
    logic [POS_W-1:0] orow_reg;
    logic [POS_W-1:0] ocol_reg;
    logic             olast_reg;

    //------------------------------------------------------------------
    // Configuration writes: always accepted, unknown indexes dropped.
    //------------------------------------------------------------------
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_cfg_reg  <= CFG_W'(WIDTH_RESET);
            height_cfg_reg <= CFG_W'(HEIGHT_RESET);
            ksize_cfg_reg  <= KSZ_W'(KSIZE_RESET);
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                CFG_IMAGE_WIDTH:  width_cfg_reg  <= cfg.data;
                CFG_IMAGE_HEIGHT: height_cfg_reg <= cfg.data;
                CFG_KERNEL_SIZE:  ksize_cfg_reg  <= cfg.data[KSZ_W-1:0];
                default:          ;
            endcase
        end
    end

    // Clip the registers to usable values: zero reads as one, oversize as the
    // maximum, and an even kernel drops to the odd size below it, or to one if zero.
    always_comb
    begin
        if (width_cfg_reg == '0)
            w_eff = CNT_W'(1);
        else if (width_cfg_reg > CFG_W'(MAX_WIDTH))
            w_eff = CNT_W'(MAX_WIDTH);
        else
            w_eff = CNT_W'(width_cfg_reg);

        if (height_cfg_reg == '0)
            h_eff = CNT_W'(1);
        else if (height_cfg_reg > CFG_W'(MAX_HEIGHT))
            h_eff = CNT_W'(MAX_HEIGHT);
        else
            h_eff = CNT_W'(height_cfg_reg);

        if (ksize_cfg_reg > KSZ_W'(MAX_KERNEL))
            k_eff = KSZ_W'(MAX_KERNEL);
        else
            k_eff = ksize_cfg_reg;
        if (!k_eff[0])
            k_eff = (k_eff == '0) ? KSZ_W'(1) : k_eff - KSZ_W'(1);

        half = (k_eff - KSZ_W'(1)) >> 1;
    end

    //------------------------------------------------------------------
    // Request decode and raster bookkeeping.
    //------------------------------------------------------------------
    assign pixel.ready = en;
    assign take        = pixel.valid & en;
    assign is_stream   = (pixel.kind == KIND_PIXEL) || (pixel.kind == KIND_DRAIN);
    assign is_load     = (pixel.kind == KIND_LOAD) && (pixel.coef_index < CIDX_W'(NTAP));
    assign sample_a    = (pixel.kind == KIND_PIXEL) ?
                         {pixel.blue_in, pixel.green_in, pixel.red_in} : '0;

    // A result is due once the raster position is half a kernel of rows and
    // columns past the result's center. Compare whole raster positions, since
    // half a kernel may span more than one row of a narrow image.
    always_comb
    begin
        pos_a   = (2*CNT_W)'(in_row_reg) * (2*CNT_W)'(w_eff) + (2*CNT_W)'(in_col_reg);
        delay_a = (2*CNT_W)'(half) * (2*CNT_W)'(w_eff) + (2*CNT_W)'(half);
        emit_a  = (pos_a >= delay_a);
        last_a  = emit_a &&
                  ((out_row_reg > h_eff - CNT_W'(1)) ||
                   ((out_row_reg == h_eff - CNT_W'(1)) && (out_col_reg >= w_eff - CNT_W'(1))));
    end

    // Which window rows and columns fall inside the image for this center.
    always_comb
    begin
        logic [CNT_W:0] rt;
        logic [CNT_W:0] ct;
        rt = {1'b0, out_row_reg} + (CNT_W+1)'(half);
        ct = {1'b0, out_col_reg} + (CNT_W+1)'(half);
        for (int j = 0; j < MAX_KERNEL; j++)
        begin
            rowok_a[j] = (rt >= (CNT_W+1)'(j)) && ((rt - (CNT_W+1)'(j)) < {1'b0, h_eff});
            colok_a[j] = (ct >= (CNT_W+1)'(j)) && ((ct - (CNT_W+1)'(j)) < {1'b0, w_eff});
        end
    end

    always_comb
    begin
        in_col_inc   = in_col_reg + CNT_W'(1);
        out_col_inc  = out_col_reg + CNT_W'(1);
        in_row_next  = in_row_reg;
        in_col_next  = in_col_reg;
        out_row_next = out_row_reg;
        out_col_next = out_col_reg;
        if (take && is_stream)
        begin
            if (in_col_inc >= w_eff)
            begin
                in_col_next = '0;
                in_row_next = in_row_reg + CNT_W'(1);
            end
            else
            begin
                in_col_next = in_col_inc;
            end
            if (last_a)
            begin
                // frame done: restart every counter
                in_row_next  = '0;
                in_col_next  = '0;
                out_row_next = '0;
                out_col_next = '0;
            end
            else if (emit_a)
            begin
                if (out_col_inc >= w_eff)
                begin
                    out_col_next = '0;
                    out_row_next = out_row_reg + CNT_W'(1);
                end
                else
                begin
                    out_col_next = out_col_inc;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_row_reg  <= '0;
            in_col_reg  <= '0;
            out_row_reg <= '0;
            out_col_reg <= '0;
        end
        else
        begin
            in_row_reg  <= in_row_next;
            in_col_reg  <= in_col_next;
            out_row_reg <= out_row_next;
            out_col_reg <= out_col_next;
        end
    end

    //------------------------------------------------------------------
    // Sequencer stage register; the line RAM read is issued alongside.
    //------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg  <= 1'b0;
            a_stream_reg <= 1'b0;
            a_load_reg   <= 1'b0;
            a_tag_reg    <= '0;
        end
        else if (en)
        begin
            a_valid_reg    <= take && (is_stream || is_load);
            a_stream_reg   <= take && is_stream;
            a_load_reg     <= take && is_load;
            a_tag_reg.emit <= take && is_stream && emit_a;
            a_tag_reg.last <= last_a;
            a_tag_reg.row  <= out_row_reg;
            a_tag_reg.col  <= out_col_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_rowok_reg  <= rowok_a;
            a_colok_reg  <= colok_a;
            a_sample_reg <= sample_a;
            a_addr_reg   <= in_col_reg[ADDR_W-1:0];
            a_cidx_reg   <= pixel.coef_index;
            a_cval_reg   <= pixel.coef_value;
        end
    end

    //------------------------------------------------------------------
    // Line buffer and window.
    //------------------------------------------------------------------
    always_comb
    begin
        win_ctrl.en    = en;
        win_ctrl.push  = a_valid_reg & a_stream_reg;
        win_ctrl.raddr = in_col_reg[ADDR_W-1:0];
        win_ctrl.waddr = a_addr_reg;
    end

    rgbc_window u_window (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (win_ctrl),
        .sample (a_sample_reg),
        .win    (win)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_load_reg <= 1'b0;
            b_tag_reg  <= '0;
        end
        else if (en)
        begin
            b_load_reg <= a_valid_reg & a_load_reg;
            b_tag_reg  <= a_tag_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            b_rowok_reg <= a_rowok_reg;
            b_colok_reg <= a_colok_reg;
            b_cidx_reg  <= a_cidx_reg;
            b_cval_reg  <= a_cval_reg;
        end
    end

    // Coefficient loads commit at the stage that reads them, so requests
    // ahead keep the old set and requests behind see the new one.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int t = 0; t < NTAP; t++)
            begin
                coef_reg[t] <= '0;
            end
        end
        else if (en && b_load_reg)
        begin
            coef_reg[b_cidx_reg] <= b_cval_reg;
        end
    end

    // Window register (j, x) holds the sample j rows and x columns back from
    // the newest, so it meets kernel tap (K-1-j, K-1-x). Zero taps that lie
    // outside the kernel or outside the image.
    always_comb
    begin
        logic  ok;
        coef_t csel;
        int    t;
        for (int j = 0; j < MAX_KERNEL; j++)
        begin
            for (int x = 0; x < MAX_KERNEL; x++)
            begin
                t    = j * MAX_KERNEL + x;
                ok   = (j < int'(k_eff)) && (x < int'(k_eff)) && b_rowok_reg[j] && b_colok_reg[x];
                csel = '0;
                for (int kk = 1; kk <= MAX_KERNEL; kk += 2)
                begin
                    if ((k_eff == KSZ_W'(kk)) && (j < kk) && (x < kk))
                        csel = coef_reg[(kk - 1 - j) * kk + (kk - 1 - x)];
                end
                lane_coef[t] = ok ? csel : '0;
                for (int c = 0; c < NCHAN; c++)
                begin
                    lane_pix[c][t] = ok ? win[j][x][c*PIX_W +: PIX_W] : '0;
                end
            end
        end
    end

    //------------------------------------------------------------------
    // Color lanes: red, green, blue side by side.
    //------------------------------------------------------------------
    for (genvar c = 0; c < NCHAN; c++)
    begin : g_lane
        rgbc_lane u_lane (
            .clk  (clk),
            .en   (en),
            .pix  (lane_pix[c]),
            .coef (lane_coef),
            .acc  (lane_acc[c])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_tag_reg  <= '0;
            s1_tag_reg <= '0;
            s2_tag_reg <= '0;
        end
        else if (en)
        begin
            p_tag_reg  <= b_tag_reg;
            s1_tag_reg <= p_tag_reg;
            s2_tag_reg <= s1_tag_reg;
        end
    end

    //------------------------------------------------------------------
    // Merge the lanes into one result. Hold the pipe only when a finished
    // result would land on one that has not been taken.
    //------------------------------------------------------------------
    assign en = !s2_tag_reg.emit || !out_valid_reg || result.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en && s2_tag_reg.emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en && s2_tag_reg.emit)
        begin
            red_reg   <= finish_pix(lane_acc[0]);
            green_reg <= finish_pix(lane_acc[1]);
            blue_reg  <= finish_pix(lane_acc[2]);
            orow_reg  <= s2_tag_reg.row[POS_W-1:0];
            ocol_reg  <= s2_tag_reg.col[POS_W-1:0];
            olast_reg <= s2_tag_reg.last;
        end
    end

    assign result.valid      = out_valid_reg;
    assign result.red_out    = red_reg;
    assign result.green_out  = green_reg;
    assign result.blue_out   = blue_reg;
    assign result.out_row    = orow_reg;
    assign result.out_col    = ocol_reg;
    assign result.frame_last = olast_reg;

endmodule
